// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// types, round constants and word functions shared by the compression block
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

	localparam logic [1:0] ACT_MSG  = 2'd0;
	localparam logic [1:0] ACT_CV   = 2'd1;
	localparam logic [1:0] ACT_INIT = 2'd2;

	localparam logic [3:0] LAST_MSG_IDX = 4'd15;
	localparam logic [5:0] LAST_ROUND   = 6'd63;
	localparam logic [2:0] LAST_DIGEST  = 3'd7;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] word_value;
		logic [3:0]  word_index;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} out_t;

	typedef struct packed {
		logic       msg_wr;
		logic       cv_wr;
		logic       cv_init;
		logic       ld_block;
		logic       round;
		logic [5:0] round_idx;
		logic       add_cv;
		logic       emit;
		logic [2:0] emit_idx;
		logic       last;
	} ctrl_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
		rotr = (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] v);
		bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] v);
		bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] v);
		ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] v);
		ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] init_word(input logic [2:0] i);
		case (i)
			3'd0: init_word = 32'h6a09e667;
			3'd1: init_word = 32'hbb67ae85;
			3'd2: init_word = 32'h3c6ef372;
			3'd3: init_word = 32'ha54ff53a;
			3'd4: init_word = 32'h510e527f;
			3'd5: init_word = 32'h9b05688c;
			3'd6: init_word = 32'h1f83d9ab;
			default: init_word = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		case (i)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_compression.sv
// ----------------------------------------------------------------------------
// sha256_compression
// sha-256 compression over one padded block with eight-word chaining value
// ----------------------------------------------------------------------------
// words 0..14, chaining loads and restores leave busy low.
// message word 15 keeps busy high through 64 rounds at one round per
// cycle in the shared round unit, the chaining add and an 8-word readout.
// the eight digest beats come on consecutive cycles from the output register
// behind the readout state; the receiver cannot stall them.
// arst_n clears the sequencer and loads the initial hash value.
`default_nettype none

`include "assert_macros.svh"

module sha256_compression (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire sha_pkg::in_t  item,
	output logic               busy,
	output logic               valid,
	output sha_pkg::out_t      result
);

	sha_pkg::ctrl_cmd_t cmd;

	sha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.cmd    (cmd)
	);

	sha_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.valid  (valid),
		.result (result)
	);

	// digest beats count up without gaps and stop after the last one
	`ASSERT_AT(a_beat_seq, valid && !result.last_word |=> valid && (result.digest_index == 3'($past(result.digest_index) + 3'd1)))
	`ASSERT_AT(a_end_run, valid && result.last_word |=> !valid)
	`ASSERT_NEVER(a_last_idx, valid && (result.last_word != (result.digest_index == 3'd7)))
	`ASSERT_AT(a_busy_cause, $rose(busy) |-> $past(start))

endmodule

`default_nettype wire

// File: rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: decodes commands, steps the 64 rounds, the add and the readout
// ----------------------------------------------------------------------------
`default_nettype none

module sha_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sha_pkg::in_t    item,
	output logic                 busy,
	output sha_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.round_idx = cnt_q;
		cmd.emit_idx  = cnt_q[2:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.action)
						sha_pkg::ACT_MSG: begin
							cmd.msg_wr = 1'b1;
							if (item.word_index == sha_pkg::LAST_MSG_IDX) begin
								cmd.ld_block = 1'b1;
								state_d      = ST_ROUND;
								cnt_d        = '0;
							end
						end
						sha_pkg::ACT_CV:   cmd.cv_wr   = !item.word_index[3];
						sha_pkg::ACT_INIT: cmd.cv_init = 1'b1;
						default: ;
					endcase
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (cnt_q == sha_pkg::LAST_ROUND) begin
					state_d = ST_ADD;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_ADD: begin
				cmd.add_cv = 1'b1;
				state_d    = ST_EMIT;
				cnt_d      = '0;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.last = (cnt_q[2:0] == sha_pkg::LAST_DIGEST);
				if (cmd.last) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha_dpath.sv
// ----------------------------------------------------------------------------
// sha_dpath
// message store, schedule window, working variables, chaining value, output
// ----------------------------------------------------------------------------
`default_nettype none

module sha_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_t       item,
	input  wire sha_pkg::ctrl_cmd_t cmd,
	output logic                    valid,
	output sha_pkg::out_t           result
);

	logic [31:0] msg_q [16];
	logic [31:0] w_q   [16];
	logic [31:0] v_q   [8];
	logic [31:0] cv_q  [8];
	logic        valid_q;
	sha_pkg::out_t res_q;

	logic [31:0] t1, t2, w_next, ch, maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch + sha_pkg::round_k(cmd.round_idx)
		+ w_q[0];
	assign t2  = sha_pkg::bsig0(v_q[0]) + maj;
	// window holds w[t..t+15], this is w[t+16]
	assign w_next = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];

	always_ff @(posedge clk) begin
		if (cmd.msg_wr) begin
			msg_q[item.word_index] <= item.word_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_block) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= msg_q[i];
			end
			w_q[15] <= item.word_value;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= cv_q[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
			// e takes d plus t1, a takes t1 plus t2, the rest shift down
			for (int i = 1; i < 8; i++) begin
				if (i != 4) begin
					v_q[i] <= v_q[i - 1];
				end
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= sha_pkg::init_word(3'(i));
			end
		end else if (cmd.cv_init) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= sha_pkg::init_word(3'(i));
			end
		end else if (cmd.cv_wr) begin
			cv_q[item.word_index[2:0]] <= item.word_value;
		end else if (cmd.add_cv) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= cv_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.digest_word  <= cv_q[cmd.emit_idx];
			res_q.digest_index <= cmd.emit_idx;
			res_q.last_word    <= cmd.last;
		end
	end

	assign valid  = valid_q;
	assign result = res_q;

endmodule

`default_nettype wire
